/* hw/rtl/bmf_pkg.sv */
// Shared types, register codes and the border mirror function of the box mean filter.
`timescale 1ns / 1ps

package bmf_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_KERNEL = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // Item kinds
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // Fixed field widths
    localparam int CFG_DW = 11;
    localparam int ROW_W  = 11;
    localparam int IDX_W  = 16;

    typedef logic signed [IDX_W-1:0] t_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_COL,
        S_SUMEND,
        S_DIV,
        S_DIVW,
        S_OUT
    } t_state;

    // Reflect-101 border, then clamp to the frame for frames narrower than the window
    function automatic t_idx mirror(input t_idx i, input t_idx n);
        t_idx v;
        v = i;
        if (v < 0) v = -v;
        if (v > n - t_idx'(1)) v = ((n - t_idx'(1)) <<< 1) - v;
        if (v < 0) v = '0;
        if (v > n - t_idx'(1)) v = n - t_idx'(1);
        return v;
    endfunction

endpackage

/* hw/rtl/bmf_cell.sv */
// One restoring subtract step of a divider chain, registered toward its neighbor.
`timescale 1ns / 1ps

module bmf_cell #(
    parameter int RW    = 14,
    parameter int DW    = 6,
    parameter int QW    = 8,
    parameter int SHIFT = 0
) (
    input  logic          i_clk,
    input  logic [RW-1:0] i_rem,
    input  logic [QW-1:0] i_quo,
    input  logic [DW-1:0] i_div,
    output logic [RW-1:0] o_rem,
    output logic [QW-1:0] o_quo
);

    localparam int XW = RW + DW + QW;

    logic [XW-1:0] dsh;
    logic          take;
    logic [RW-1:0] n_rem;
    logic [QW-1:0] n_quo;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_quo;

    // Try the shifted divisor against the partial remainder
    always_comb begin
        dsh   = XW'(i_div) << SHIFT;
        take  = (XW'(i_rem) >= dsh);
        n_rem = take ? RW'(XW'(i_rem) - dsh) : i_rem;
        n_quo = take ? (i_quo | (QW'(1) << SHIFT)) : i_quo;
    end

    // Hand the step result to the next cell
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

/* hw/rtl/bmf_chain.sv */
// Row of restoring divider cells; one quotient bit per cell, one cell per cycle.
`timescale 1ns / 1ps

module bmf_chain #(
    parameter int NCELL = 8,
    parameter int RW    = 14,
    parameter int DW    = 6,
    parameter int QW    = 8
) (
    input  logic          i_clk,
    input  logic [RW-1:0] i_dvd,
    input  logic [DW-1:0] i_div,
    output logic [RW-1:0] o_rem,
    output logic [QW-1:0] o_quo
);

    logic [RW-1:0] rem [0:NCELL];
    logic [QW-1:0] quo [0:NCELL];

    assign rem[0] = i_dvd;
    assign quo[0] = '0;

    // Highest quotient bit first
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        bmf_cell #(
            .RW   (RW),
            .DW   (DW),
            .QW   (QW),
            .SHIFT(NCELL - 1 - g)
        ) u_cell (
            .i_clk(i_clk),
            .i_rem(rem[g]),
            .i_quo(quo[g]),
            .i_div(i_div),
            .o_rem(rem[g+1]),
            .o_quo(quo[g+1])
        );
    end

    assign o_rem = rem[NCELL];
    assign o_quo = quo[NCELL];

endmodule

/* hw/rtl/box_mean_filter.sv */
// Sequence: an item with no result is taken in S_IDLE and the block stays there; for an
// item with a result, per window row S_ROW maps the row to its line-store slot, then S_COL
// makes K single-port store reads; an 8-cell divider chain ends it (S_DIV, S_DIVW).
// Throughput: one item at a time; the next transfer is taken back in S_IDLE after the result
// is registered, and a register write stalls the input.
// Reset: synchronous, active low; registers return to K=3, 640x480, counters zero.
`timescale 1ns / 1ps

module box_mean_filter #(
    parameter int MAX_KERNEL = 7,
    parameter int MAX_WIDTH  = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_req_type,
    input  logic [7:0]                 i_pixel_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [7:0]                 o_mean_out,
    output logic                       o_frame_end,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [bmf_pkg::CFG_DW-1:0] i_cfg_data
);

    localparam int R     = MAX_KERNEL + 1;
    localparam int SLW   = $clog2(R);
    localparam int AW    = $clog2(R * MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CLW   = $clog2(MAX_WIDTH);
    localparam int KW    = $clog2(MAX_KERNEL + 1);
    localparam int KKW   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int SW    = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
    localparam int CW    = CLW + 13;
    localparam int KMAXO = (MAX_KERNEL % 2 == 0) ? MAX_KERNEL - 1 : MAX_KERNEL;
    localparam int RWD   = bmf_pkg::ROW_W;
    localparam int DIVN  = 8;
    localparam int CNW   = 4;
    // Reciprocal of the slot count for the row-to-slot remainder
    localparam int RCS   = RWD + $clog2(R);
    localparam int RCM   = ((1 << RCS) + R - 1) / R;
    localparam int PW    = 2 * RWD + 2;

    // Configuration and derived frame geometry
    logic [2:0]        r_ks;
    logic [RWD-1:0]    r_wcfg;
    logic [RWD-1:0]    r_hcfg;
    logic              r_cfg_busy;
    logic [KW-1:0]     r_k;
    logic [KW-1:0]     r_half;
    logic [WW-1:0]     r_w;
    logic [RWD-1:0]    r_h;
    logic [CW-1:0]     r_lag;
    logic [CW-1:0]     r_total;
    logic [KKW-1:0]    r_kk;
    logic [KW-1:0]     n_k;
    logic [WW-1:0]     n_w;
    logic [RWD-1:0]    n_h;

    // Position state
    logic [CLW-1:0]    r_in_col;
    logic [RWD-1:0]    r_in_row;
    logic [SLW-1:0]    r_in_slot;
    logic [CLW-1:0]    r_out_col;
    logic [RWD-1:0]    r_out_row;
    logic [CW-1:0]     r_opos;
    logic [CW-1:0]     r_items;

    // Sequencer
    bmf_pkg::t_state   r_state;
    bmf_pkg::t_state   n_state;
    logic [KW-1:0]     r_j;
    logic [KW-1:0]     r_c;
    logic [CNW-1:0]    r_cnt;
    logic [SLW-1:0]    r_slot;
    logic              r_pend;
    logic [SW-1:0]     r_sum;
    logic [7:0]        r_mean_q;
    logic [7:0]        r_rd;

    // Output register
    logic              r_out_valid;
    logic [7:0]        r_mean;
    logic              r_fend;

    logic [7:0]        mem [0:R*MAX_WIDTH-1];

    logic              in_xfer;
    logic              cfg_xfer;
    logic              cfg_hit;
    logic              due;
    logic              last;
    logic              out_free;
    logic              store_wr;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    bmf_pkg::t_idx     row_i;
    bmf_pkg::t_idx     col_i;
    bmf_pkg::t_idx     rr;
    bmf_pkg::t_idx     cc;
    logic [PW-1:0]     row_prod;
    logic [RWD-1:0]    row_q;
    logic [RWD-1:0]    row_slot;
    logic [SW-1:0]     div_rem;
    logic [7:0]        div_quo;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;
    assign cfg_hit  = cfg_xfer && (i_cfg_index inside
                      {bmf_pkg::CFG_KERNEL, bmf_pkg::CFG_WIDTH, bmf_pkg::CFG_HEIGHT});
    assign out_free = !r_out_valid || !i_out_stall;
    assign due      = (r_items + CW'(1)) > (r_lag + r_opos);
    assign last     = (r_opos + CW'(1)) >= r_total;
    assign store_wr = in_xfer && (r_in_row < r_h);

    // Clamp the configuration to the supported range
    always_comb begin
        int k1;
        int wi;
        k1 = int'({r_ks[2:1], 1'b1});
        wi = int'(r_wcfg);
        if (k1 > KMAXO) k1 = KMAXO;
        if (wi < 1) wi = 1;
        if (wi > MAX_WIDTH) wi = MAX_WIDTH;
        n_k = KW'(k1);
        n_w = WW'(wi);
        n_h = (r_hcfg == '0) ? RWD'(1) : r_hcfg;
    end

    // Register the geometry derived from the configuration
    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_half  <= KW'((n_k - KW'(1)) >> 1);
        r_w     <= n_w;
        r_h     <= n_h;
        r_lag   <= CW'(KW'((n_k - KW'(1)) >> 1)) * CW'(n_w)
                   + CW'(KW'((n_k - KW'(1)) >> 1));
        r_total <= CW'(n_w) * CW'(n_h);
        r_kk    <= KKW'(n_k) * KKW'(n_k);
    end

    // Take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks       <= 3'd3;
            r_wcfg     <= RWD'(640);
            r_hcfg     <= RWD'(480);
            r_cfg_busy <= 1'b1;
        end else begin
            r_cfg_busy <= cfg_hit;
            if (cfg_xfer) begin
                case (i_cfg_index)
                    bmf_pkg::CFG_KERNEL: r_ks   <= i_cfg_data[2:0];
                    bmf_pkg::CFG_WIDTH:  r_wcfg <= i_cfg_data;
                    bmf_pkg::CFG_HEIGHT: r_hcfg <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Window coordinates with the border mirrored
    always_comb begin
        row_i = $signed(bmf_pkg::IDX_W'(r_out_row)) + $signed(bmf_pkg::IDX_W'(r_j))
                - $signed(bmf_pkg::IDX_W'(r_half));
        col_i = $signed(bmf_pkg::IDX_W'(r_out_col)) + $signed(bmf_pkg::IDX_W'(r_c))
                - $signed(bmf_pkg::IDX_W'(r_half));
        rr    = bmf_pkg::mirror(row_i, $signed(bmf_pkg::IDX_W'(r_h)));
        cc    = bmf_pkg::mirror(col_i, $signed(bmf_pkg::IDX_W'(r_w)));
        raddr = AW'(r_slot) * AW'(MAX_WIDTH) + AW'(cc[CLW-1:0]);
        waddr = AW'(r_in_slot) * AW'(MAX_WIDTH) + AW'(r_in_col);
    end

    // Row to store slot: remainder by the slot count through its reciprocal
    always_comb begin
        row_prod = PW'(rr[RWD-1:0]) * PW'(RCM);
        row_q    = RWD'(row_prod >> RCS);
        row_slot = rr[RWD-1:0] - RWD'(row_q * RWD'(R));
    end

    // Window sum over K*K
    bmf_chain #(
        .NCELL(DIVN),
        .RW   (SW),
        .DW   (KKW),
        .QW   (8)
    ) u_div (
        .i_clk(i_clk),
        .i_dvd(r_sum),
        .i_div(r_kk),
        .o_rem(div_rem),
        .o_quo(div_quo)
    );

    // Line store
    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            mem[waddr] <= (i_req_type == bmf_pkg::REQ_DRAIN) ? 8'd0 : i_pixel_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bmf_pkg::S_COL) begin
            r_rd <= mem[raddr];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bmf_pkg::S_IDLE:   if (in_xfer && due) n_state = bmf_pkg::S_ROW;
            bmf_pkg::S_ROW:    n_state = bmf_pkg::S_COL;
            bmf_pkg::S_COL: begin
                if (r_c == r_k - KW'(1)) begin
                    n_state = (r_j == r_k - KW'(1)) ? bmf_pkg::S_SUMEND : bmf_pkg::S_ROW;
                end
            end
            bmf_pkg::S_SUMEND: n_state = bmf_pkg::S_DIV;
            bmf_pkg::S_DIV:    n_state = bmf_pkg::S_DIVW;
            bmf_pkg::S_DIVW:   if (r_cnt == '0) n_state = bmf_pkg::S_OUT;
            bmf_pkg::S_OUT:    if (out_free) n_state = bmf_pkg::S_IDLE;
            default:           n_state = bmf_pkg::S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_in_stall  = (r_state != bmf_pkg::S_IDLE) || r_cfg_busy || i_cfg_valid;
        o_cfg_ready = (r_state == bmf_pkg::S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk the window and accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_j    <= '0;
            r_c    <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= (r_state == bmf_pkg::S_COL);
            if (r_pend) r_sum <= r_sum + SW'(r_rd);
            case (r_state)
                bmf_pkg::S_IDLE: begin
                    r_sum <= '0;
                    r_j   <= '0;
                end
                bmf_pkg::S_ROW: begin
                    r_slot <= row_slot[SLW-1:0];
                    r_c    <= '0;
                end
                bmf_pkg::S_COL: begin
                    if (r_c == r_k - KW'(1)) r_j <= r_j + KW'(1);
                    else r_c <= r_c + KW'(1);
                end
                bmf_pkg::S_DIV: r_cnt <= CNW'(DIVN - 1);
                bmf_pkg::S_DIVW: begin
                    if (r_cnt == '0) r_mean_q <= div_quo;
                    else r_cnt <= r_cnt - CNW'(1);
                end
                default: ;
            endcase
        end
    end

    // Advance input and output positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_slot <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_opos    <= '0;
            r_items   <= '0;
        end else if (in_xfer) begin
            r_items <= r_items + CW'(1);
            if (store_wr) begin
                if (WW'(r_in_col) + WW'(1) >= r_w) begin
                    r_in_col  <= '0;
                    r_in_row  <= r_in_row + RWD'(1);
                    r_in_slot <= (r_in_slot == SLW'(R - 1)) ? '0 : r_in_slot + SLW'(1);
                end else begin
                    r_in_col <= r_in_col + CLW'(1);
                end
            end
        end else if (r_state == bmf_pkg::S_OUT && out_free) begin
            if (last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_in_slot <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_opos    <= '0;
                r_items   <= '0;
            end else begin
                r_opos <= r_opos + CW'(1);
                if (WW'(r_out_col) + WW'(1) >= r_w) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + RWD'(1);
                end else begin
                    r_out_col <= r_out_col + CLW'(1);
                end
            end
        end
    end

    // Output register: hold while stalled, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == bmf_pkg::S_OUT && out_free) begin
            r_out_valid <= 1'b1;
            r_mean      <= r_mean_q;
            r_fend      <= last;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_mean_out  = r_mean;
    assign o_frame_end = r_fend;

    // Input column stays inside the row
    a_in_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cfg_busy |-> (WW'(r_in_col) < r_w))
        else $error("input column beyond row width");

    // Output position stays inside the frame
    a_opos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cfg_busy |-> (r_opos < r_total))
        else $error("output position beyond frame");

    // A finished result waits while the output register is held
    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmf_pkg::S_OUT && r_out_valid && i_out_stall)
        |=> (r_state == bmf_pkg::S_OUT))
        else $error("result left before output register freed");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the box mean filter: random frames, idles and stalls.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [7:0] mean;
        logic       last;
    } t_window_result;

    // Bit-level prediction of the filter output stream
    class bmf_scoreboard;
        logic [7:0]     rows [0:8191];
        int             ks, wd, ht;
        int             in_col, in_row, out_col, out_row, seen;
        int             errors;
        t_window_result due_q[$];

        function new();
            ks = 3;
            wd = 640;
            ht = 480;
            errors = 0;
            clear_pos();
        endfunction

        function void clear_pos();
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            seen = 0;
        endfunction

        function int reflect_idx(int i, int n);
            if (i < 0) i = -i;
            if (i > n - 1) i = 2 * (n - 1) - i;
            if (i < 0) i = 0;
            if (i > n - 1) i = n - 1;
            return i;
        endfunction

        function void note_cfg(logic [1:0] idx, logic [bmf_pkg::CFG_DW-1:0] d);
            if (idx == bmf_pkg::CFG_KERNEL) ks = d[2:0];
            else if (idx == bmf_pkg::CFG_WIDTH) wd = d;
            else if (idx == bmf_pkg::CFG_HEIGHT) ht = d;
            else return;
            clear_pos();
        endfunction

        // Store the item, then emit a window mean once the lag is covered
        function void note_item(logic req, logic [7:0] px);
            int k, w, h, half, lag, total, opos, sum, rr, cc;
            t_window_result r;
            k = ks | 1;
            if (k > 7) k = 7;
            half = (k - 1) / 2;
            w = (wd < 1) ? 1 : ((wd > 1024) ? 1024 : wd);
            h = (ht < 1) ? 1 : ht;
            lag = half * w + half;
            total = w * h;
            if (in_row < h) begin
                rows[(in_row % 8) * 1024 + in_col] = (req == bmf_pkg::REQ_DRAIN) ? 8'd0 : px;
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                end
            end
            seen++;
            opos = out_row * w + out_col;
            if (seen <= lag + opos) return;
            sum = 0;
            for (int dy = -half; dy <= half; dy++) begin
                rr = reflect_idx(out_row + dy, h);
                for (int dx = -half; dx <= half; dx++) begin
                    cc = reflect_idx(out_col + dx, w);
                    sum += rows[(rr % 8) * 1024 + cc];
                end
            end
            r.mean = 8'(sum / (k * k));
            r.last = (opos + 1 >= total);
            due_q.push_back(r);
            if (r.last) begin
                clear_pos();
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        endtask

        task check(logic [7:0] mean, logic last);
            t_window_result r;
            if (due_q.size() == 0) begin
                report("unexpected transfer", mean, -1);
                return;
            end
            r = due_q.pop_front();
            if (mean !== r.mean) report("mean_out", mean, r.mean);
            if (last !== r.last) report("frame_end", last, r.last);
        endtask

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_req_type = bmf_pkg::REQ_PIXEL;
    logic [7:0]                 i_pixel_in = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [7:0]                 o_mean_out;
    logic                       o_frame_end;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [1:0]                 i_cfg_index = bmf_pkg::CFG_KERNEL;
    logic [bmf_pkg::CFG_DW-1:0] i_cfg_data = '0;

    bmf_scoreboard sb = new();
    int            send_idle_pct = 21;
    int            recv_stall_pct = 58;
    int            hold_left = 0;
    bit            hold_req = 1'b0;
    bit            hold_done = 1'b0;
    int            items_sent = 0;

    box_mean_filter uut (.*);

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver stalls, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check every output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check(o_mean_out, o_frame_end);
    end

    task send_item(logic req, logic [7:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_pixel_in <= px;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(req, px);
        items_sent++;
    endtask

    task write_reg(logic [1:0] idx, logic [bmf_pkg::CFG_DW-1:0] d);
        i_in_valid <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_cfg(idx, d);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until every result is in, then let the block settle
    task wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task set_frame(int ks, int w, int h);
        wait_drained();
        write_reg(bmf_pkg::CFG_KERNEL, bmf_pkg::CFG_DW'(ks));
        write_reg(bmf_pkg::CFG_WIDTH, bmf_pkg::CFG_DW'(w));
        write_reg(bmf_pkg::CFG_HEIGHT, bmf_pkg::CFG_DW'(h));
    endtask

    // One frame of pixels plus its drain ticks, with some misplaced kinds
    task send_frame(bit extremes);
        int k, half, w, h, total;
        logic [7:0] px;
        k = sb.ks | 1;
        if (k > 7) k = 7;
        half = (k - 1) / 2;
        w = (sb.wd < 1) ? 1 : ((sb.wd > 1024) ? 1024 : sb.wd);
        h = (sb.ht < 1) ? 1 : sb.ht;
        total = w * h;
        for (int i = 0; i < total + half * w + half; i++) begin
            px = extremes ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
            if (i < total) begin
                send_item(($urandom_range(15) == 0) ? bmf_pkg::REQ_DRAIN : bmf_pkg::REQ_PIXEL,
                          px);
            end else begin
                send_item(($urandom_range(15) == 0) ? bmf_pkg::REQ_PIXEL : bmf_pkg::REQ_DRAIN,
                          px);
            end
        end
    endtask

    task random_phase();
        int ks, k, half;
        ks = $urandom_range(7);
        k = ks | 1;
        half = (k - 1) / 2;
        set_frame(ks, $urandom_range(12, half + 1), $urandom_range(8, half + 1));
        repeat ($urandom_range(3, 1)) send_frame($urandom_range(7) == 0);
    endtask

    initial begin
        bit held;
        held = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single-pixel frame, ignored index, largest kernel, even kernel
        set_frame(0, 0, 0);
        send_item(bmf_pkg::REQ_PIXEL, 8'hFF);
        write_reg(2'd3, '1);
        send_item(bmf_pkg::REQ_DRAIN, 8'hAA);
        set_frame(7, 4, 4);
        send_frame(1'b1);
        set_frame(2, 5, 4);
        send_frame(1'b0);

        // Random frames across the three idle modes
        while (items_sent < 480) begin
            if (items_sent < 160) begin
                send_idle_pct = 21;
                recv_stall_pct = 58;
            end else if (items_sent < 320) begin
                send_idle_pct = 58;
                recv_stall_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            if (!held && items_sent >= 380) begin
                // Long receiver hold-off while the frame keeps coming
                held = 1'b1;
                set_frame(3, 12, 8);
                hold_req = 1'b1;
                send_frame(1'b0);
            end else begin
                random_phase();
            end
        end

        // Tall single column, then a return to the reset setting's kernel
        set_frame(1, 1, 100);
        send_frame(1'b0);
        set_frame(3, 6, 5);
        send_frame(1'b0);

        wait_drained();
        if (sb.errors == 0) begin
            $display("** box_mean_filter: PASSED **");
        end else begin
            $display("** box_mean_filter: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #40ms;
        $display("** box_mean_filter: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/bmf_pkg.sv
hw/rtl/bmf_cell.sv
hw/rtl/bmf_chain.sv
hw/rtl/box_mean_filter.sv
bench/tb_top.sv
